// ----- design/tuk_pkg.sv -----
// Shared types, constants and the quarter-wave cosine table of the Tukey window block.
package tuk_pkg;

    localparam int MAX_LENGTH      = 4096;
    localparam int ADDR_W          = $clog2(MAX_LENGTH);
    localparam int LEN_W           = ADDR_W + 1;
    localparam int COEF_W          = 31;
    localparam int COEF_FRAC_BITS  = 30;
    localparam int FRAC_W          = 17;
    localparam int SUM_W           = 43;
    localparam int COS_TABLE_DEPTH = 1024;
    localparam int COS_LOG         = $clog2(COS_TABLE_DEPTH);
    localparam int COS_IDX_W       = COS_LOG + 1;
    localparam int COS_FRAC_W      = 30 - COS_LOG;
    localparam int COS_W           = 31;
    localparam int DEN_W           = 28;
    localparam int DIV_N_W         = 62;
    localparam int DIV_D_W         = SUM_W;
    localparam int DIV_CNT_W       = $clog2(DIV_N_W + 1);
    localparam int CFG_IDX_W       = 2;

    localparam logic [FRAC_W:0]   FRAC_ONE = 18'd65536;
    localparam logic [COS_W-1:0]  Q30_ONE  = 31'd1073741824;
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(Q30_ONE) << (COEF_FRAC_BITS - 30);

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPER     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE = 2'd2;

    localparam logic ACT_BUILD = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Taylor series divisors (2n)*(2n-1) for n = 1..7
    localparam longint unsigned TAYLOR_DEN [1:7] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182
    };

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_UNBUILT = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_ENTRY, S_PHASE, S_COS, S_WR_LO, S_WR_HI, S_CENTRE,
        S_N_READ, S_N_GO, S_N_DIV, S_N_WR_LO, S_N_WR_HI, S_N_ADJ, S_FINISH
    } t_state;

    // result waiting between the store read and the output register
    typedef struct packed {
        logic    valid;
        logic    use_mem;
        t_status status;
    } t_pend;

    typedef logic [COS_TABLE_DEPTH:0][COS_W-1:0] t_cos_tab;

    // cos(pi/2*k/D) by a Horner Taylor series in Q31, rounded to Q30
    function automatic t_cos_tab f_cos_tab();
        t_cos_tab        tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned term;
        longint unsigned v;
        for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
            x  = (64'd6746518852 * longint'(k) + COS_TABLE_DEPTH) >> (COS_LOG + 1);
            x2 = (x * x) >> 31;
            t  = 64'd2147483648;
            for (int n = 7; n >= 1; n--) begin
                term = ((x2 * t) >> 31) / TAYLOR_DEN[n];
                t    = (term >= 64'd2147483648) ? 64'd0 : 64'd2147483648 - term;
            end
            v = (t + 64'd1) >> 1;
            tab[k] = (v > 64'(Q30_ONE)) ? Q30_ONE : v[COS_W-1:0];
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = f_cos_tab();

endpackage

// ----- design/tuk_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tuk_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/tuk_div.sv -----
// Restoring divider, one quotient bit per cycle.
module tuk_div
    import tuk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_num,
    input  logic [DIV_D_W-1:0] i_den,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quo
);
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_den;
    logic [DIV_D_W:0]     trial;
    logic                 fits;

    assign trial = {r_rem, r_quo[DIV_N_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= DIV_CNT_W'(DIV_N_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? DIV_D_W'(trial - {1'b0, r_den}) : trial[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_cnt == '0))
        else $error("divider started while busy");
    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_cnt == '0) && $past(r_cnt) == DIV_CNT_W'(1))
        else $error("divider done without a full pass");
`endif
endmodule

// ----- design/tuk_cos.sv -----
// Quarter-wave cosine lookup with linear interpolation, computed as a sequence of registered steps.
module tuk_cos
    import tuk_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [COS_W-1:0] i_angle,
    output logic             o_done,
    output logic [COS_W-1:0] o_mag
);
    logic [2:0]                   r_stage;
    logic                         r_done;
    logic [COS_IDX_W-1:0]         r_idx;
    logic [COS_FRAC_W-1:0]        r_frac;
    logic [COS_W-1:0]             r_hi;
    logic [COS_W-1:0]             r_lo;
    logic                         r_down;
    logic [COS_W+COS_FRAC_W-1:0]  r_prod;
    logic [COS_W-1:0]             r_mag;
    logic [COS_IDX_W-1:0]         idx_nxt;
    logic [COS_W-1:0]             diff;
    logic [COS_W+COS_FRAC_W:0]    rnd_sum;
    logic [COS_W-1:0]             rnd;

    assign idx_nxt = (r_idx >= COS_IDX_W'(COS_TABLE_DEPTH)) ? r_idx : r_idx + 1'b1;
    assign diff    = (r_hi >= r_lo) ? r_hi - r_lo : r_lo - r_hi;
    assign rnd_sum = {1'b0, r_prod} + ((COS_W+COS_FRAC_W+1)'(1) << (COS_FRAC_W - 1));
    assign rnd     = COS_W'(rnd_sum >> COS_FRAC_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 3'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_stage <= 3'd1;
            end else if (r_stage == 3'd4) begin
                r_stage <= 3'd0;
                r_done  <= 1'b1;
            end else if (r_stage != 3'd0) begin
                r_stage <= r_stage + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_stage)
            3'd1: r_hi <= COS_TAB[r_idx];
            3'd2: r_lo <= COS_TAB[idx_nxt];
            3'd3: begin
                r_down <= r_hi >= r_lo;
                r_prod <= diff * r_frac;
            end
            3'd4: r_mag <= r_down ? r_hi - rnd : r_hi + rnd;
            default: begin
                if (i_start) begin
                    r_idx  <= i_angle[COS_W-1:COS_FRAC_W];
                    r_frac <= i_angle[COS_FRAC_W-1:0];
                end
            end
        endcase
    end

    assign o_done = r_done;
    assign o_mag  = r_mag;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_stage == 3'd0))
        else $error("cosine lookup started while busy");
`endif
endmodule

// ----- design/tukey_window_generator_core.sv -----
// Top level: Tukey window builder and coefficient store with read channel.
// Read item: store read, then output register; one read item per cycle while idle and the
// output is not stalled. Build item: per first-half entry an entry check, in the tapered
// region a wait on the 62-step divider, then on the cosine lookup, and two store writes;
// normalizing adds a read, a division and two writes. The result follows the last write.
// Synchronous active-low reset: control registers reset, window unbuilt; store not cleared.
module tukey_window_generator_core
    import tuk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FRAC_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_action,
    input  logic [ADDR_W-1:0]    i_index,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [COEF_W-1:0]    o_coefficient,
    output logic [1:0]           o_status
);
    t_state r_state, n_state;

    logic [LEN_W-1:0]  r_cfg_len;
    logic [FRAC_W-1:0] r_cfg_taper;
    logic              r_cfg_norm;
    logic              r_built;

    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_half;
    logic              r_odd;
    logic [DEN_W-1:0]  r_den;
    logic [29:0]       r_rl;
    logic              r_taper_on;
    logic [ADDR_W-1:0] r_l;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_s2;
    logic [COEF_W-1:0] r_val;
    logic [COEF_W-1:0] r_c;
    logic              r_neg;

    t_pend             r_pend;
    logic              r_out_valid;
    logic [COEF_W-1:0] r_out_coef;
    t_status           r_out_status;

    logic [LEN_W-1:0]  len_sat;
    logic [FRAC_W:0]   taper_sat;
    logic              out_load;
    logic              in_acc;
    logic              rd_acc;
    t_status           rd_status;
    logic [ADDR_W-1:0] mirror;
    logic              taper_here;
    logic [SUM_W-1:0]  sum_centre;
    logic [COEF_W:0]   c_up;
    logic [SUM_W-1:0]  s2_excess;
    logic [SUM_W-1:0]  s2_short;
    logic [COEF_W-1:0] c_adj;
    logic [31:0]       taper_raw;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [COEF_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [COEF_W-1:0] ram_rdata;

    logic               div_start;
    logic [DIV_N_W-1:0] div_num;
    logic [DIV_D_W-1:0] div_den;
    logic               div_done;
    logic [DIV_N_W-1:0] div_quo;

    logic               cos_start;
    logic [COS_W-1:0]   cos_angle;
    logic               cos_done;
    logic [COS_W-1:0]   cos_mag;

    // saturate configuration
    always_comb begin
        if (r_cfg_len < LEN_W'(2)) begin
            len_sat = LEN_W'(2);
        end else if (r_cfg_len > LEN_W'(MAX_LENGTH)) begin
            len_sat = LEN_W'(MAX_LENGTH);
        end else begin
            len_sat = r_cfg_len;
        end
        taper_sat = ({1'b0, r_cfg_taper} > FRAC_ONE) ? FRAC_ONE : {1'b0, r_cfg_taper};
    end

    assign out_load   = r_pend.valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE) && (!r_pend.valid || out_load);
    assign in_acc     = i_in_valid && o_in_ready;
    assign rd_acc     = in_acc && (i_action == ACT_READ);
    assign mirror     = ADDR_W'(r_len - LEN_W'(1) - {1'b0, r_l});
    assign taper_here = r_taper_on && ({r_l, 17'd0} < r_rl);
    assign sum_centre = r_odd ? r_sum + SUM_W'(COEF_ONE) : r_sum;

    always_comb begin
        if (!r_built) begin
            rd_status = ST_UNBUILT;
        end else if ({1'b0, i_index} >= len_sat) begin
            rd_status = ST_RANGE;
        end else begin
            rd_status = ST_OK;
        end
    end

    // centre correction so the scaled window sums to one
    assign s2_excess = r_s2 - SUM_W'(COEF_ONE);
    assign s2_short  = SUM_W'(COEF_ONE) - r_s2;
    assign c_up      = {1'b0, r_c} + s2_short[COEF_W:0];
    always_comb begin
        if (r_s2 > SUM_W'(COEF_ONE)) begin
            c_adj = (s2_excess > SUM_W'(r_c)) ? '0 : r_c - s2_excess[COEF_W-1:0];
        end else begin
            c_adj = c_up[COEF_W] ? {COEF_W{1'b1}} : c_up[COEF_W-1:0];
        end
    end

    assign taper_raw = r_neg ? 32'(Q30_ONE) + 32'(cos_mag) + 32'd1
                             : 32'(Q30_ONE) - 32'(cos_mag) + 32'd1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (in_acc && i_action == ACT_BUILD) n_state = S_INIT;
            S_INIT:    n_state = S_ENTRY;
            S_ENTRY:   n_state = taper_here ? S_PHASE : S_WR_LO;
            S_PHASE:   if (div_done) n_state = S_COS;
            S_COS:     if (cos_done) n_state = S_WR_LO;
            S_WR_LO:   n_state = S_WR_HI;
            S_WR_HI:   n_state = (r_l == r_half - 1'b1) ? S_CENTRE : S_ENTRY;
            S_CENTRE:  n_state = (r_cfg_norm && sum_centre != '0) ? S_N_READ : S_FINISH;
            S_N_READ:  n_state = S_N_GO;
            S_N_GO:    n_state = S_N_DIV;
            S_N_DIV:   if (div_done) n_state = S_N_WR_LO;
            S_N_WR_LO: n_state = (r_l == r_half) ? S_N_ADJ : S_N_WR_HI;
            S_N_WR_HI: n_state = (!r_odd && r_l == r_half - 1'b1) ? S_N_ADJ : S_N_READ;
            S_N_ADJ:   n_state = S_FINISH;
            S_FINISH:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // unit and store controls
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_l;
        ram_wdata = r_val;
        ram_re    = 1'b0;
        ram_raddr = r_l;
        div_start = 1'b0;
        div_num   = DIV_N_W'({r_l, 48'd0}) + DIV_N_W'(r_den >> 1);
        div_den   = DIV_D_W'(r_den);
        cos_start = 1'b0;
        cos_angle = div_quo[30] ? Q30_ONE - COS_W'(div_quo[29:0]) : COS_W'(div_quo[29:0]);
        unique case (r_state)
            S_IDLE: begin
                ram_re    = rd_acc;
                ram_raddr = i_index;
            end
            S_ENTRY:   div_start = taper_here;
            S_PHASE:   cos_start = div_done;
            S_WR_LO:   ram_we = 1'b1;
            S_WR_HI: begin
                ram_we    = 1'b1;
                ram_waddr = mirror;
            end
            S_CENTRE: begin
                ram_we    = r_odd;
                ram_waddr = r_half;
                ram_wdata = COEF_ONE;
            end
            S_N_READ:  ram_re = 1'b1;
            S_N_GO: begin
                div_start = 1'b1;
                div_num   = DIV_N_W'({ram_rdata, 30'd0}) + DIV_N_W'(r_sum >> 1);
                div_den   = r_sum;
            end
            S_N_WR_LO: ram_we = 1'b1;
            S_N_WR_HI: begin
                ram_we    = 1'b1;
                ram_waddr = mirror;
            end
            S_N_ADJ: begin
                ram_we    = 1'b1;
                ram_waddr = r_half;
                ram_wdata = c_adj;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_len   <= LEN_W'(MAX_LENGTH);
            r_cfg_taper <= FRAC_W'(32768);
            r_cfg_norm  <= 1'b0;
            r_built     <= 1'b0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_LENGTH:    r_cfg_len   <= i_cfg_data[LEN_W-1:0];
                    REG_TAPER:     r_cfg_taper <= i_cfg_data;
                    REG_NORMALIZE: r_cfg_norm  <= i_cfg_data[0];
                    default: ;
                endcase
                if (i_cfg_index <= REG_NORMALIZE) begin
                    r_built <= 1'b0;
                end
            end
            if (r_state == S_FINISH) begin
                r_built <= 1'b1;
            end
            if (rd_acc) begin
                r_pend <= '{valid: 1'b1, use_mem: (rd_status == ST_OK), status: rd_status};
            end else if (r_state == S_FINISH) begin
                r_pend <= '{valid: 1'b1, use_mem: 1'b0, status: ST_OK};
            end else if (out_load) begin
                r_pend.valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT:   r_sum <= '0;
                S_WR_LO,
                S_WR_HI:  r_sum <= r_sum + SUM_W'(r_val);
                S_CENTRE: r_sum <= sum_centre;
                default: ;
            endcase
        end
    end

    // build datapath and output result registers
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_coef   <= r_pend.use_mem ? ram_rdata : '0;
            r_out_status <= r_pend.status;
        end
        case (r_state)
            S_INIT: begin
                r_len      <= len_sat;
                r_half     <= ADDR_W'(len_sat >> 1);
                r_odd      <= len_sat[0];
                r_den      <= DEN_W'((len_sat - LEN_W'(1)) * taper_sat);
                r_rl       <= 30'(taper_sat * len_sat);
                r_taper_on <= taper_sat != '0;
                r_l        <= '0;
                r_s2       <= '0;
            end
            S_ENTRY: r_val <= COEF_ONE;
            S_PHASE: r_neg <= div_quo[31] ^ div_quo[30];
            S_COS: begin
                if (cos_done) begin
                    r_val <= COEF_W'(taper_raw >> 1) << (COEF_FRAC_BITS - 30);
                end
            end
            S_WR_HI:   r_l <= r_l + 1'b1;
            S_CENTRE:  r_l <= '0;
            S_N_DIV: begin
                if (div_done) begin
                    r_val <= div_quo[COEF_W-1:0];
                end
            end
            S_N_WR_LO: begin
                r_s2 <= r_s2 + SUM_W'(r_val);
                if (r_l == r_half) begin
                    r_c <= r_val;
                end
            end
            S_N_WR_HI: begin
                r_s2 <= r_s2 + SUM_W'(r_val);
                if (mirror == r_half) begin
                    r_c <= r_val;
                end
                r_l <= r_l + 1'b1;
            end
            default: ;
        endcase
    end

    tuk_ram #(
        .WIDTH(COEF_W),
        .DEPTH(MAX_LENGTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    tuk_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    tuk_cos u_cos (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(cos_start),
        .i_angle(cos_angle),
        .o_done (cos_done),
        .o_mag  (cos_mag)
    );

    assign o_out_valid   = r_out_valid;
    assign o_coefficient = r_out_coef;
    assign o_status      = r_out_status;

`ifndef NO_ASSERTIONS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_coefficient == '0)
        else $error("error result carries a coefficient");
    a_no_status3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != 2'd3)
        else $error("undefined status code");
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !o_in_ready)
        else $error("store written while items are accepted");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend.valid && r_pend.use_mem && !out_load |=> $stable(ram_rdata))
        else $error("pending read data lost");
`endif
endmodule

// ----- tb/tb_tukey_window_checker.sv -----
// Checker for the Tukey window block: watches both channels and the register port, predicts, compares.
`timescale 1ns / 1ps
module tb_tukey_window_checker
    import tuk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FRAC_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_action,
    input  logic [ADDR_W-1:0]    i_index,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [COEF_W-1:0]    i_coefficient,
    input  logic [1:0]           i_status,
    output int                   o_fail_count,
    output int                   o_waiting
);

    typedef struct {
        logic [COEF_W-1:0] coef;
        t_status           st;
    } t_coef_result;

    localparam longint unsigned QUARTER_ONE = 64'd1073741824;
    localparam longint unsigned QUARTER_MASK = 64'd1073741823;

    longint unsigned   cos_lut [0:COS_TABLE_DEPTH];
    logic [COEF_W-1:0] win_store [0:MAX_LENGTH-1];
    logic [12:0]       cfg_length;
    logic [16:0]       cfg_taper;
    logic              cfg_norm;
    logic              win_ready;
    logic [SUM_W-1:0]  win_sum;
    t_coef_result      coef_fifo[$];

    assign o_waiting = coef_fifo.size();

    initial begin
        longint unsigned x, x2, t, term, v;
        o_fail_count = 0;
        for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
            x  = (64'd6746518852 * longint'(k) + COS_TABLE_DEPTH) / (2 * COS_TABLE_DEPTH);
            x2 = (x * x) >> 31;
            t  = 64'd2147483648;
            for (int n = 7; n >= 1; n--) begin
                term = ((x2 * t) >> 31) / longint'((2 * n) * (2 * n - 1));
                t    = (term >= 64'd2147483648) ? 64'd0 : 64'd2147483648 - term;
            end
            v = (t + 64'd1) >> 1;
            cos_lut[k] = (v > QUARTER_ONE) ? QUARTER_ONE : v;
        end
    end

    function automatic longint unsigned eff_length();
        longint unsigned len;
        len = cfg_length;
        if (len < 2) len = 2;
        if (len > MAX_LENGTH) len = MAX_LENGTH;
        return len;
    endfunction

    function automatic longint unsigned scale_q30(longint unsigned q30);
        int sh;
        if (COEF_FRAC_BITS >= 30) return q30 << (COEF_FRAC_BITS - 30);
        sh = 30 - COEF_FRAC_BITS;
        return (q30 + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // interpolate the quarter-wave table; angle in quarter turns, Q30
    function automatic longint unsigned interp_cos(longint unsigned a);
        longint unsigned s, i, f, hi, lo;
        s = a * COS_TABLE_DEPTH;
        i = s >> 30;
        f = s & QUARTER_MASK;
        if (i >= COS_TABLE_DEPTH) return cos_lut[COS_TABLE_DEPTH];
        hi = cos_lut[i];
        lo = cos_lut[i + 1];
        if (hi >= lo) return hi - (((hi - lo) * f + (64'd1 << 29)) >> 30);
        return hi + (((lo - hi) * f + (64'd1 << 29)) >> 30);
    endfunction

    function automatic longint unsigned taper_coef(longint unsigned l, longint unsigned len,
                                                   longint unsigned r);
        longint unsigned den, ph, quad, p, m;
        bit neg;
        den  = (len - 1) * r;
        ph   = (((l << 48) + den / 2) / den) & 64'hFFFF_FFFF;
        quad = ph >> 30;
        p    = ph & QUARTER_MASK;
        case (quad)
            0:       begin m = interp_cos(p);               neg = 0; end
            1:       begin m = interp_cos(QUARTER_ONE - p); neg = 1; end
            2:       begin m = interp_cos(p);               neg = 1; end
            default: begin m = interp_cos(QUARTER_ONE - p); neg = 0; end
        endcase
        return scale_q30(neg ? (QUARTER_ONE + m + 1) >> 1 : (QUARTER_ONE - m + 1) >> 1);
    endfunction

    task automatic build_window();
        longint unsigned len, r, one, half, sum, s2, c, d;
        longint unsigned w [0:MAX_LENGTH-1];
        len  = eff_length();
        r    = cfg_taper;
        if (r > 65536) r = 65536;
        one  = scale_q30(QUARTER_ONE);
        half = len / 2;
        sum  = 0;
        for (longint unsigned l = 0; l < half; l++)
            w[l] = (r != 0 && 2 * l * 65536 < r * len) ? taper_coef(l, len, r) : one;
        if (len[0]) w[half] = one;
        for (longint unsigned l = len - half; l < len; l++) w[l] = w[len - 1 - l];
        for (longint unsigned l = 0; l < len; l++) sum += w[l];
        win_sum = sum[SUM_W-1:0];
        if (cfg_norm && sum != 0) begin
            s2 = 0;
            for (longint unsigned l = 0; l < len; l++) begin
                w[l] = (w[l] * one + sum / 2) / sum;
                s2 += w[l];
            end
            // fold the rounding residue into the centre entry
            c = w[half];
            if (s2 > one) begin
                d = s2 - one;
                c = (d > c) ? 0 : c - d;
            end else begin
                c += one - s2;
                if (c > 64'h7FFF_FFFF) c = 64'h7FFF_FFFF;
            end
            w[half] = c;
        end
        for (longint unsigned l = 0; l < len; l++) win_store[l] = w[l][COEF_W-1:0];
        win_ready = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_coef_result exp_r, got;
        if (!i_rst_n) begin
            cfg_length = 13'd4096;
            cfg_taper  = 17'd32768;
            cfg_norm   = 1'b0;
            win_ready  = 1'b0;
            win_sum    = '0;
            coef_fifo.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LENGTH:    cfg_length = i_cfg_data[12:0];
                    REG_TAPER:     cfg_taper  = i_cfg_data[16:0];
                    REG_NORMALIZE: cfg_norm   = i_cfg_data[0];
                    default: ;
                endcase
                if (i_cfg_index <= REG_NORMALIZE) win_ready = 1'b0;
            end
            if (i_in_valid && i_in_ready) begin
                exp_r.coef = '0;
                exp_r.st   = ST_OK;
                if (i_action == ACT_BUILD) build_window();
                else if (!win_ready) exp_r.st = ST_UNBUILT;
                else if (i_index >= eff_length()) exp_r.st = ST_RANGE;
                else exp_r.coef = win_store[i_index];
                coef_fifo.push_back(exp_r);
            end
            if (i_out_valid && i_out_ready) begin
                if (coef_fifo.size() == 0) begin
                    $error("unexpected result item: coefficient %0d status %0d",
                           i_coefficient, i_status);
                    o_fail_count++;
                end else begin
                    got = coef_fifo.pop_front();
                    if (i_coefficient !== got.coef) begin
                        $error("coefficient: expected %0d, got %0d", got.coef, i_coefficient);
                        o_fail_count++;
                    end
                    if (i_status !== got.st) begin
                        $error("status: expected %0d, got %0d", got.st, i_status);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/tb_tukey_window_generator_core.sv -----
// Testbench top: stimulus, flow control and verdict for the Tukey window block.
`timescale 1ns / 1ps
module tb_tukey_window_generator_core;
    import tuk_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [FRAC_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_action = ACT_READ;
    logic [ADDR_W-1:0]    i_index = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [COEF_W-1:0]    o_coefficient;
    logic [1:0]           o_status;
    int                   fail_count;
    int                   waiting;
    int                   cycles = 0;
    int                   stall_left = 0;
    bit                   out_took = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    tukey_window_generator_core u_dut (.*);

    tb_tukey_window_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_action, .i_index,
        .i_out_valid(o_out_valid), .i_out_ready, .i_coefficient(o_coefficient),
        .i_status(o_status), .o_fail_count(fail_count), .o_waiting(waiting)
    );

    always @(posedge i_clk) begin
        out_took = o_out_valid && i_out_ready;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // draw a fresh stall after every result item, with bursts of none
    always @(negedge i_clk) begin
        if (out_took) stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
        out_took = 0;
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    function automatic int sat_length(int len);
        if (len < 2) return 2;
        if (len > MAX_LENGTH) return MAX_LENGTH;
        return len;
    endfunction

    task automatic send_item(logic act, logic [ADDR_W-1:0] idx);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action   = act;
        i_index    = idx;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold until every expected item has arrived, then let the block settle
    task automatic drain();
        i_in_valid = 1'b0;
        while (waiting != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_regs(int len, int taper, int norm);
        i_cfg_we = 1'b1;
        i_cfg_index = REG_LENGTH;    i_cfg_data = FRAC_W'(len);   @(negedge i_clk);
        i_cfg_index = REG_TAPER;     i_cfg_data = FRAC_W'(taper); @(negedge i_clk);
        i_cfg_index = REG_NORMALIZE; i_cfg_data = FRAC_W'(norm);  @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic read_random(int len);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)       send_item(ACT_READ, ADDR_W'($urandom_range(0, len - 1)));
        else if (pick < 9)  send_item(ACT_READ, ADDR_W'(len + $urandom_range(0, 3) - 2));
        else                send_item(ACT_READ, ADDR_W'($urandom_range(0, 4095)));
    endtask

    task automatic run_phase(int len_reg, int taper, int norm, int n_items);
        int len;
        len = sat_length(len_reg);
        drain();
        write_regs(len_reg, taper, norm);
        send_item(ACT_READ, ADDR_W'($urandom_range(0, 4095)));
        send_item(ACT_BUILD, ADDR_W'($urandom_range(0, 4095)));
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 14) == 0) send_item(ACT_BUILD, ADDR_W'($urandom));
            else read_random(len);
        end
    endtask

    initial begin
        int len;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reads before any build, then edge indices on a full-length all-ones window
        send_item(ACT_READ, 12'd0);
        send_item(ACT_READ, 12'hFFF);
        drain();
        write_regs(8191, 0, 0);
        send_item(ACT_BUILD, 12'hFFF);
        send_item(ACT_READ, 12'd0);
        send_item(ACT_READ, 12'd2048);
        send_item(ACT_READ, 12'hFFF);
        send_item(ACT_READ, 12'h555);
        send_item(ACT_READ, 12'hAAA);
        run_phase(0, 65536, 1, 4);
        run_phase(7, 131071, 1, 4);
        run_phase(9, 1, 1, 4);
        run_phase(4096, 65536, 0, 3);
        send_item(ACT_READ, 12'd4095);

        for (int p = 0; p < 13; p++) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 300) : $urandom_range(2, 64);
            case ($urandom_range(0, 4))
                0:       run_phase(len, 0, $urandom_range(0, 1), 33);
                1:       run_phase(len, $urandom_range(65536, 131071), $urandom_range(0, 1), 33);
                default: run_phase(len, $urandom_range(1, 65536), $urandom_range(0, 1), 33);
            endcase
        end

        drain();
        if (fail_count == 0 && waiting == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/tuk_pkg.sv
design/tuk_ram.sv
design/tuk_div.sv
design/tuk_cos.sv
design/tukey_window_generator_core.sv
tb/tb_tukey_window_checker.sv
tb/tb_tukey_window_generator_core.sv
